@@ rtl/core/pfc_pkg.sv @@
// package: widths, register indexes, reset values and microcode for the pi controller
`timescale 1ns / 1ps
package pfc_pkg;

    localparam int LUX_W           = 14;
    localparam int GAIN_W          = 16;
    localparam int DB_W            = 14;
    localparam int DUTY_W          = 8;
    localparam int FF_W            = 10;
    localparam int ACC_W           = 32;
    localparam int ACC_FRAC_DEF    = 12;
    localparam int PROD_FRAC       = 12;
    localparam int IN_TDATA_W      = ((3 * LUX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W     = DUTY_W;
    localparam int OUT_TUSER_W     = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int NUM_W           = LUX_W - 4 + PROD_FRAC;
    localparam int CNT_W           = $clog2(NUM_W);
    localparam int DUTY_MAX        = 255;
    localparam int FF_MAX          = 1023;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANT_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = 3'd4;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd256;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd0;
    localparam logic [GAIN_W-1:0] PLANT_GAIN_RST = 16'd4096;
    localparam logic [DB_W-1:0]   DEAD_BAND_RST  = 14'd16;

    typedef enum logic [3:0] {
        OP_ERR,
        OP_DIV,
        OP_FF,
        OP_MULP,
        OP_UP,
        OP_MULI,
        OP_UI,
        OP_SUM1,
        OP_SUM2,
        OP_CMP,
        OP_BASE,
        OP_BACK,
        OP_WRITE
    } op_t;

    localparam int UC_DEPTH = 13;
    localparam int UC_AW    = $clog2(UC_DEPTH);

    localparam logic [UC_AW-1:0] UC_DIV_ADDR = UC_AW'(1);

    typedef struct packed {
        op_t              op;
        logic             loop;
        logic             last;
        logic [UC_AW-1:0] target;
    } ucode_t;

    function automatic ucode_t uc_rom(input logic [UC_AW-1:0] addr);
        ucode_t w;
        w = '{op: OP_WRITE, loop: 1'b0, last: 1'b0, target: '0};
        unique case (addr)
            UC_AW'(0):  w.op = OP_ERR;
            UC_AW'(1): begin
                w.op     = OP_DIV;
                w.loop   = 1'b1;
                w.target = UC_DIV_ADDR;
            end
            UC_AW'(2):  w.op = OP_FF;
            UC_AW'(3):  w.op = OP_MULP;
            UC_AW'(4):  w.op = OP_UP;
            UC_AW'(5):  w.op = OP_MULI;
            UC_AW'(6):  w.op = OP_UI;
            UC_AW'(7):  w.op = OP_SUM1;
            UC_AW'(8):  w.op = OP_SUM2;
            UC_AW'(9):  w.op = OP_CMP;
            UC_AW'(10): w.op = OP_BASE;
            UC_AW'(11): w.op = OP_BACK;
            default: begin
                w.op   = OP_WRITE;
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/pi_feedforward_antiwindup_controller.sv @@
// pi light controller with feedforward and anti-windup, microcoded datapath
// an item runs through the microcode from input accept to m_tvalid, and the write step waits on m_tready
// while the previous result is still held; the 22-step serial divider loop of the
// feedforward takes most of the run, the remaining microcode steps run once each
// a new item is accepted while the previous result still waits in the output register
// reset (aresetn low, synchronous): registers to defaults, integral to zero, no item held
`timescale 1ns / 1ps
module pi_feedforward_antiwindup_controller #(
    parameter int ACC_FRAC_BITS = pfc_pkg::ACC_FRAC_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // reference_lux [13:0], measured_lux [27:14], simulated_lux [41:28], zero fill
    input  logic [pfc_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // duty [7:0]
    output logic [pfc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // clamped_high [0], clamped_low [1], integral_held [2]
    output logic [pfc_pkg::OUT_TUSER_W-1:0]   m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pfc_pkg::*;

    localparam int SW  = ((ACC_FRAC_BITS > PROD_FRAC) ? ACC_FRAC_BITS : PROD_FRAC) + 26;
    localparam int PW  = GAIN_W + 1 + LUX_W + 1;
    localparam int SHL = (ACC_FRAC_BITS >= PROD_FRAC) ? ACC_FRAC_BITS - PROD_FRAC : 0;
    localparam int SHR = (ACC_FRAC_BITS < PROD_FRAC) ? PROD_FRAC - ACC_FRAC_BITS : 0;
    localparam logic signed [SW-1:0] TOP     = SW'(DUTY_MAX) <<< ACC_FRAC_BITS;
    localparam logic signed [SW-1:0] I32_MAX = SW'({1'b0, {(ACC_W-1){1'b1}}});
    localparam logic signed [SW-1:0] I32_MIN = -I32_MAX - SW'(1);

    // configuration
    logic              mode_reg;
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] integ_gain_reg;
    logic [GAIN_W-1:0] plant_gain_reg;
    logic [DB_W-1:0]   dead_band_reg;

    // sequencer
    logic             busy_reg, busy_next;
    logic [UC_AW-1:0] pc_reg, pc_next;
    logic             m_valid_reg, m_valid_next;
    ucode_t           uc;
    logic             out_free;
    logic             exec;

    // datapath
    logic [LUX_W-1:0]         ref_reg, meas_reg, sim_reg;
    logic signed [LUX_W:0]    e_ref_reg, e_pi_reg;
    logic [GAIN_W-1:0]        rem_reg;
    logic [NUM_W-1:0]         dq_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [SW-1:0]     up_reg, ui_reg, ff_reg, acc_reg, base_reg;
    logic                     hi_reg, lo_reg;
    logic signed [ACC_W-1:0]  integ_reg;
    logic [DUTY_W-1:0]        duty_reg;
    logic [OUT_TUSER_W-1:0]   flags_reg;

    logic signed [GAIN_W:0]   gain_op;
    logic signed [PW-1:0]     mul_res;
    logic signed [SW-1:0]     prod_acc;
    logic [GAIN_W:0]          trial;
    logic                     trial_ge;
    logic [GAIN_W:0]          trial_diff;
    logic [FF_W-1:0]          ff_q;
    logic [LUX_W-1:0]         e_mag;
    logic                     held;
    logic signed [ACC_W-1:0]  ui_sat;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = duty_reg;
    assign m_tuser   = flags_reg;

    assign uc       = uc_rom(pc_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign exec     = busy_reg && (uc.op != OP_WRITE || out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b0;
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            plant_gain_reg <= PLANT_GAIN_RST;
            dead_band_reg  <= DEAD_BAND_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MODE:       mode_reg       <= cfg_data[0];
                CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                CFG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                CFG_PLANT_GAIN: plant_gain_reg <= cfg_data;
                CFG_DEAD_BAND:  dead_band_reg  <= cfg_data[DB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (!busy_reg) begin
            if (s_tvalid) begin
                busy_next = 1'b1;
                pc_next   = '0;
            end
        end else if (exec) begin
            if (uc.op == OP_WRITE) begin
                m_valid_next = 1'b1;
            end
            if (uc.loop && cnt_reg != '0) begin
                pc_next = uc.target;
            end else if (uc.last) begin
                busy_next = 1'b0;
            end else begin
                pc_next = pc_reg + UC_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign gain_op  = $signed({1'b0, (uc.op == OP_MULI) ? integ_gain_reg : prop_gain_reg});
    assign mul_res  = gain_op * e_pi_reg;
    assign prod_acc = (SW'(prod_reg) <<< SHL) >>> SHR;

    assign trial      = {rem_reg, dq_reg[NUM_W-1]};
    assign trial_ge   = trial >= {1'b0, plant_gain_reg};
    assign trial_diff = trial - {1'b0, plant_gain_reg};
    assign ff_q       = (|dq_reg[NUM_W-1:FF_W]) ? FF_W'(FF_MAX) : dq_reg[FF_W-1:0];

    assign e_mag  = e_ref_reg[LUX_W] ? LUX_W'(-e_ref_reg) : LUX_W'(e_ref_reg);
    assign held   = e_mag < dead_band_reg;
    assign ui_sat = (ui_reg > I32_MAX) ? I32_MAX[ACC_W-1:0] :
                    (ui_reg < I32_MIN) ? I32_MIN[ACC_W-1:0] : ui_reg[ACC_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
        end else if (exec && uc.op == OP_WRITE && !held) begin
            integ_reg <= ui_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ref_reg  <= s_tdata[LUX_W-1:0];
            meas_reg <= s_tdata[2*LUX_W-1:LUX_W];
            sim_reg  <= s_tdata[3*LUX_W-1:2*LUX_W];
        end
        if (exec) begin
            unique case (uc.op)
                OP_ERR: begin
                    e_ref_reg <= $signed({1'b0, ref_reg}) - $signed({1'b0, meas_reg});
                    e_pi_reg  <= mode_reg ? $signed({1'b0, sim_reg}) - $signed({1'b0, meas_reg})
                                          : $signed({1'b0, ref_reg}) - $signed({1'b0, meas_reg});
                    rem_reg   <= '0;
                    dq_reg    <= {ref_reg[LUX_W-1:4], {PROD_FRAC{1'b0}}};
                    cnt_reg   <= CNT_W'(NUM_W - 1);
                end
                OP_DIV: begin
                    rem_reg <= trial_ge ? trial_diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
                    dq_reg  <= {dq_reg[NUM_W-2:0], trial_ge};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                OP_FF:   ff_reg   <= mode_reg ? (SW'(ff_q) <<< ACC_FRAC_BITS) : '0;
                OP_MULP: prod_reg <= mul_res;
                OP_UP:   up_reg   <= prod_acc;
                OP_MULI: prod_reg <= mul_res;
                OP_UI:   ui_reg   <= SW'(integ_reg) + prod_acc;
                OP_SUM1: acc_reg  <= up_reg + ui_reg;
                OP_SUM2: acc_reg  <= acc_reg + ff_reg;
                OP_CMP: begin
                    hi_reg <= acc_reg > TOP;
                    lo_reg <= acc_reg < 0;
                end
                OP_BASE: base_reg <= (hi_reg ? TOP : '0) - ff_reg;
                OP_BACK: begin
                    if (hi_reg || lo_reg) begin
                        ui_reg  <= base_reg - up_reg;
                        acc_reg <= hi_reg ? TOP : '0;
                    end
                end
                OP_WRITE: begin
                    duty_reg  <= acc_reg[ACC_FRAC_BITS +: DUTY_W];
                    flags_reg <= {held, lo_reg, hi_reg};
                end
                default: ;
            endcase
        end
    end

    a_clamp_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(flags_reg[0] && flags_reg[1]))
        else $error("clamped high and low together");

    a_clamp_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && flags_reg[0]) |-> duty_reg == DUTY_W'(DUTY_MAX))
        else $error("clamped high without full duty");

    a_low_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && flags_reg[1]) |-> duty_reg == '0)
        else $error("clamped low without zero duty");

    a_integ_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(integ_reg) |-> $past(exec && uc.op == OP_WRITE && !held))
        else $error("integral changed outside its write step");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(busy_reg && uc.op == OP_WRITE))
        else $error("result raised outside the write step");

endmodule
